// ===== src/ray_disc_intersection_defines.svh =====
// Assertion macros for the ray/disc intersection block.
// No dependencies; included by the files that assert.
`ifndef RAY_DISC_INTERSECTION_DEFINES_SVH
`define RAY_DISC_INTERSECTION_DEFINES_SVH

// Implication checked on every rising edge outside reset
`define RDI_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define RDI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rdi_pkg.sv =====
// Constants, register codes and types for the ray/disc intersection block.
// No dependencies.
package rdi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int AXIS_W    = 18;
   localparam int RADIUS_W  = 31;
   localparam int EPS_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Dot product widths
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PPROD_W  = DIFF_W + AXIS_W;
   localparam int NPROD_W  = COORD_W + AXIS_W;
   localparam int DOT_W    = PPROD_W + 2;
   localparam int MAG_W    = DOT_W - 1;
   localparam int LIM_W    = EPS_W + FRAC_BITS;

   // Division: quotient bits and the shift used for the range check
   localparam int OVF_SH   = 33;
   localparam int QUO_W    = FRAC_BITS + OVF_SH;

   // Offset and hit point widths
   localparam int LO_W     = 2 * COORD_W;
   localparam int HI_W     = QUO_W - COORD_W + COORD_W;
   localparam int PROD_W   = QUO_W + COORD_W;
   localparam int OFF_W    = 34;
   localparam int CAND_W   = OFF_W + 2;
   localparam int D_W      = CAND_W + 1;
   localparam int DMAG_W   = COORD_W - 1;
   localparam int SQ_W     = 2 * DMAG_W;
   localparam int SUM_W    = SQ_W + 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_Z   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_EPSILON  = 3'd7;

   // Ray carried down the pipeline
   typedef struct packed {
      logic [2:0][COORD_W-1:0] org;
      logic [2:0][COORD_W-1:0] dir;
   } ray_type;

endpackage

// ===== src/ray_disc_intersection.sv =====
// Ray/disc intersection engine: a 58-stage pipeline with a one-bit-per-stage divider.
// Depends on rdi_pkg and ray_disc_intersection_defines.svh.
//
// Usage:
//   req_*  : one ray per item (origin, direction, signed Q16.16).
//   rsp_*  : one result per ray (hit flag, hit point, back-side flag);
//            hit point and back-side flag read zero on a miss.
//   csr_*  : register writes (index 0..7), always ready; write only while
//            no ray is in flight.
// One ray is accepted every cycle unless a result waits at the output.
// The depth is set by the restoring divider for t, which
// resolves one quotient bit per stage over 49 stages, plus four stages of
// plane dot products and five of offset, distance and compare.
// Reset clears all stage valid bits and loads the default disc
// (centre 0, axis +z, radius 1.0, epsilon 1 lsb).
// When the receiver stalls, the whole pipeline holds in place and
// req_ready drops until the waiting result is taken.
`include "ray_disc_intersection_defines.svh"

module ray_disc_intersection import rdi_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [COORD_W-1:0]   req_origin_x,
   input  logic signed [COORD_W-1:0]   req_origin_y,
   input  logic signed [COORD_W-1:0]   req_origin_z,
   input  logic signed [COORD_W-1:0]   req_dir_x,
   input  logic signed [COORD_W-1:0]   req_dir_y,
   input  logic signed [COORD_W-1:0]   req_dir_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic signed [COORD_W-1:0]   rsp_hit_x,
   output logic signed [COORD_W-1:0]   rsp_hit_y,
   output logic signed [COORD_W-1:0]   rsp_hit_z,
   output logic                        rsp_back_side,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_data
);

   // Configuration registers
   logic signed [COORD_W-1:0]  center_ff [3];
   logic signed [AXIS_W-1:0]   axis_ff [3];
   logic [RADIUS_W-1:0]        radius_ff;
   logic [EPS_W-1:0]           eps_ff;

   logic pipe_adv;

   // Stage 1: offsets from centre
   logic                       s1_v_ff;
   ray_type                    s1_ray_ff, s1_ray_in;
   logic signed [DIFF_W-1:0]   s1_diff_ff [3];
   logic signed [DIFF_W-1:0]   s1_diff_in [3];

   // Stage 2: products with the axis
   logic                       s2_v_ff;
   ray_type                    s2_ray_ff;
   logic signed [PPROD_W-1:0]  s2_pp_ff [3];
   logic signed [PPROD_W-1:0]  s2_pp_in [3];
   logic signed [NPROD_W-1:0]  s2_np_ff [3];
   logic signed [NPROD_W-1:0]  s2_np_in [3];

   // Stage 3: dot products P and N
   logic                       s3_v_ff;
   ray_type                    s3_ray_ff;
   logic signed [DOT_W-1:0]    s3_p_ff, s3_p_in;
   logic signed [DOT_W-1:0]    s3_n_ff, s3_n_in;

   // Divider stages; entry 0 is the set-up stage
   logic                       div_v_ff    [QUO_W+1];
   ray_type                    div_ray_ff  [QUO_W+1];
   logic                       div_miss_ff [QUO_W+1];
   logic                       div_back_ff [QUO_W+1];
   logic [MAG_W-1:0]           div_an_ff   [QUO_W+1];
   logic [MAG_W-1:0]           div_rem_ff  [QUO_W+1];
   logic [QUO_W-1:0]           div_num_ff  [QUO_W+1];
   logic [QUO_W-1:0]           div_quo_ff  [QUO_W+1];

   logic [MAG_W-1:0]           set_ap, set_an;
   logic [LIM_W-1:0]           set_lim;
   logic                       set_miss_in;

   // Stage 5: partial products of t and |dir|
   logic                       s5_v_ff;
   ray_type                    s5_ray_ff;
   logic                       s5_miss_ff, s5_miss_in;
   logic                       s5_back_ff;
   logic [LO_W-1:0]            s5_lo_ff [3];
   logic [LO_W-1:0]            s5_lo_in [3];
   logic [HI_W-1:0]            s5_hi_ff [3];
   logic [HI_W-1:0]            s5_hi_in [3];

   // Stage 6: scaled offsets
   logic                       s6_v_ff;
   ray_type                    s6_ray_ff;
   logic                       s6_miss_ff, s6_miss_in;
   logic                       s6_back_ff;
   logic [OFF_W-1:0]           s6_off_ff [3];
   logic [OFF_W-1:0]           s6_off_in [3];

   // Stage 7: hit point and distance from centre
   logic                       s7_v_ff;
   logic                       s7_miss_ff, s7_miss_in;
   logic                       s7_back_ff;
   logic signed [CAND_W-1:0]   s7_cand_ff [3];
   logic signed [CAND_W-1:0]   s7_cand_in [3];
   logic [DMAG_W-1:0]          s7_dmag_ff [3];
   logic [DMAG_W-1:0]          s7_dmag_in [3];

   // Stage 8: squares
   logic                       s8_v_ff;
   logic                       s8_miss_ff;
   logic                       s8_back_ff;
   logic signed [CAND_W-1:0]   s8_cand_ff [3];
   logic [SQ_W-1:0]            s8_sq_ff [3];
   logic [SQ_W-1:0]            s8_rr_ff;

   // Output register
   logic                       out_v_ff;
   logic                       out_hit_ff, out_hit_in;
   logic                       out_back_ff;
   logic signed [COORD_W-1:0]  out_pt_ff [3];
   logic signed [COORD_W-1:0]  out_pt_in [3];
   logic [SUM_W-1:0]           out_sum;

   // Advance every stage unless a result waits at the output
   assign pipe_adv  = !out_v_ff || rsp_ready;
   assign req_ready = pipe_adv;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         axis_ff[0]   <= '0;
         axis_ff[1]   <= '0;
         axis_ff[2]   <= AXIS_W'(1 << FRAC_BITS);
         radius_ff    <= RADIUS_W'(1 << FRAC_BITS);
         eps_ff       <= EPS_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CENTER_X: center_ff[0] <= csr_data[COORD_W-1:0];
            REG_CENTER_Y: center_ff[1] <= csr_data[COORD_W-1:0];
            REG_CENTER_Z: center_ff[2] <= csr_data[COORD_W-1:0];
            REG_AXIS_X:   axis_ff[0]   <= csr_data[AXIS_W-1:0];
            REG_AXIS_Y:   axis_ff[1]   <= csr_data[AXIS_W-1:0];
            REG_AXIS_Z:   axis_ff[2]   <= csr_data[AXIS_W-1:0];
            REG_RADIUS:   radius_ff    <= csr_data[RADIUS_W-1:0];
            REG_EPSILON:  eps_ff       <= csr_data[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage 1 logic: subtract the centre
   always_comb begin
      s1_ray_in.org[0] = req_origin_x;
      s1_ray_in.org[1] = req_origin_y;
      s1_ray_in.org[2] = req_origin_z;
      s1_ray_in.dir[0] = req_dir_x;
      s1_ray_in.dir[1] = req_dir_y;
      s1_ray_in.dir[2] = req_dir_z;
      for (int i = 0; i < 3; i++) begin
         s1_diff_in[i] = DIFF_W'($signed(s1_ray_in.org[i])) - DIFF_W'(center_ff[i]);
      end
   end

   // Stage 2 logic: multiply by the axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_pp_in[i] = PPROD_W'(s1_diff_ff[i]) * PPROD_W'(axis_ff[i]);
         s2_np_in[i] = NPROD_W'($signed(s1_ray_ff.dir[i])) * NPROD_W'(axis_ff[i]);
      end
   end

   // Stage 3 logic: sum into P and N
   always_comb begin
      s3_p_in = DOT_W'(s2_pp_ff[0]) + DOT_W'(s2_pp_ff[1]) + DOT_W'(s2_pp_ff[2]);
      s3_n_in = DOT_W'(s2_np_ff[0]) + DOT_W'(s2_np_ff[1]) + DOT_W'(s2_np_ff[2]);
   end

   // Divider set-up: magnitudes, early miss tests, range check of t
   always_comb begin
      set_ap  = s3_p_ff[DOT_W-1] ? MAG_W'(-s3_p_ff) : MAG_W'(s3_p_ff);
      set_an  = s3_n_ff[DOT_W-1] ? MAG_W'(-s3_n_ff) : MAG_W'(s3_n_ff);
      set_lim = {eps_ff, {FRAC_BITS{1'b0}}};
      set_miss_in = (s3_n_ff == '0) || (set_an < MAG_W'(set_lim))
         || (set_ap < MAG_W'(set_lim)) || (s3_p_ff == '0)
         || (s3_p_ff[DOT_W-1] == s3_n_ff[DOT_W-1])
         || ({{OVF_SH{1'b0}}, set_ap} >= {set_an, {OVF_SH{1'b0}}});
   end

   // Stages 1 to 3 and divider set-up registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         div_v_ff[0] <= 1'b0;
      end else if (pipe_adv) begin
         s1_v_ff     <= req_valid;
         s2_v_ff     <= s1_v_ff;
         s3_v_ff     <= s2_v_ff;
         div_v_ff[0] <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s1_ray_ff       <= s1_ray_in;
         s1_diff_ff      <= s1_diff_in;
         s2_ray_ff       <= s1_ray_ff;
         s2_pp_ff        <= s2_pp_in;
         s2_np_ff        <= s2_np_in;
         s3_ray_ff       <= s2_ray_ff;
         s3_p_ff         <= s3_p_in;
         s3_n_ff         <= s3_n_in;
         div_ray_ff[0]   <= s3_ray_ff;
         div_miss_ff[0]  <= set_miss_in;
         div_back_ff[0]  <= !s3_n_ff[DOT_W-1];
         div_an_ff[0]    <= set_an;
         div_rem_ff[0]   <= MAG_W'(set_ap >> OVF_SH);
         div_num_ff[0]   <= {set_ap[OVF_SH-1:0], {FRAC_BITS{1'b0}}};
         div_quo_ff[0]   <= '0;
      end
   end

   // Restoring divider: one quotient bit per stage
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      logic [MAG_W:0]   trial;
      logic             take;
      logic [MAG_W-1:0] rem_in;

      always_comb begin
         trial  = {div_rem_ff[k], div_num_ff[k][QUO_W-1]};
         take   = trial >= {1'b0, div_an_ff[k]};
         rem_in = take ? MAG_W'(trial - {1'b0, div_an_ff[k]}) : MAG_W'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[k+1] <= 1'b0;
         end else if (pipe_adv) begin
            div_v_ff[k+1] <= div_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            div_ray_ff[k+1]  <= div_ray_ff[k];
            div_miss_ff[k+1] <= div_miss_ff[k];
            div_back_ff[k+1] <= div_back_ff[k];
            div_an_ff[k+1]   <= div_an_ff[k];
            div_rem_ff[k+1]  <= rem_in;
            div_num_ff[k+1]  <= {div_num_ff[k][QUO_W-2:0], 1'b0};
            div_quo_ff[k+1]  <= {div_quo_ff[k][QUO_W-2:0], take};
         end
      end
   end

   // Stage 5 logic: tiny t test and partial products of t * |dir|
   always_comb begin
      logic [COORD_W-1:0] dmag;
      s5_miss_in = div_miss_ff[QUO_W] || (div_quo_ff[QUO_W] < QUO_W'(eps_ff));
      for (int i = 0; i < 3; i++) begin
         dmag = div_ray_ff[QUO_W].dir[i][COORD_W-1] ?
                ~div_ray_ff[QUO_W].dir[i] + 1'b1 : div_ray_ff[QUO_W].dir[i];
         s5_lo_in[i] = LO_W'(div_quo_ff[QUO_W][COORD_W-1:0]) * LO_W'(dmag);
         s5_hi_in[i] = HI_W'(div_quo_ff[QUO_W][QUO_W-1:COORD_W]) * HI_W'(dmag);
      end
   end

   // Stage 6 logic: combine partial products, drop fraction bits
   always_comb begin
      logic [PROD_W-1:0] prod;
      s6_miss_in = s5_miss_ff;
      for (int i = 0; i < 3; i++) begin
         prod = {s5_hi_ff[i], {COORD_W{1'b0}}} + PROD_W'(s5_lo_ff[i]);
         s6_off_in[i] = prod[FRAC_BITS+OFF_W-1:FRAC_BITS];
         if (|prod[PROD_W-1:FRAC_BITS+OFF_W]) begin
            s6_miss_in = 1'b1;
         end
      end
   end

   // Stage 7 logic: hit point and its distance from the centre
   always_comb begin
      logic signed [CAND_W-1:0] off_s;
      logic signed [D_W-1:0]    d;
      logic [D_W-1:0]           dm;
      s7_miss_in = s6_miss_ff;
      for (int i = 0; i < 3; i++) begin
         off_s = $signed({2'b00, s6_off_ff[i]});
         s7_cand_in[i] = CAND_W'($signed(s6_ray_ff.org[i]))
                         + (s6_ray_ff.dir[i][COORD_W-1] ? -off_s : off_s);
         d  = D_W'(s7_cand_in[i]) - D_W'(center_ff[i]);
         dm = d[D_W-1] ? D_W'(-d) : D_W'(d);
         s7_dmag_in[i] = dm[DMAG_W-1:0];
         if (|dm[D_W-1:DMAG_W]) begin
            s7_miss_in = 1'b1;
         end
      end
   end

   // Stage 9 logic: sum of squares, radius compare, saturation
   always_comb begin
      out_sum    = SUM_W'(s8_sq_ff[0]) + SUM_W'(s8_sq_ff[1]) + SUM_W'(s8_sq_ff[2]);
      out_hit_in = !s8_miss_ff && (out_sum < SUM_W'(s8_rr_ff));
      for (int i = 0; i < 3; i++) begin
         if (!out_hit_in) begin
            out_pt_in[i] = '0;
         end else if (s8_cand_ff[i] > CAND_W'(32'sh7FFF_FFFF)) begin
            out_pt_in[i] = 32'sh7FFF_FFFF;
         end else if (s8_cand_ff[i] < -CAND_W'(33'sh0_8000_0000)) begin
            out_pt_in[i] = 32'sh8000_0000;
         end else begin
            out_pt_in[i] = s8_cand_ff[i][COORD_W-1:0];
         end
      end
   end

   // Back-end valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         s8_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (pipe_adv) begin
         s5_v_ff  <= div_v_ff[QUO_W];
         s6_v_ff  <= s5_v_ff;
         s7_v_ff  <= s6_v_ff;
         s8_v_ff  <= s7_v_ff;
         out_v_ff <= s8_v_ff;
      end
   end

   // Back-end payload
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s5_ray_ff   <= div_ray_ff[QUO_W];
         s5_miss_ff  <= s5_miss_in;
         s5_back_ff  <= div_back_ff[QUO_W];
         s5_lo_ff    <= s5_lo_in;
         s5_hi_ff    <= s5_hi_in;
         s6_ray_ff   <= s5_ray_ff;
         s6_miss_ff  <= s6_miss_in;
         s6_back_ff  <= s5_back_ff;
         s6_off_ff   <= s6_off_in;
         s7_miss_ff  <= s7_miss_in;
         s7_back_ff  <= s6_back_ff;
         s7_cand_ff  <= s7_cand_in;
         s7_dmag_ff  <= s7_dmag_in;
         s8_miss_ff  <= s7_miss_ff;
         s8_back_ff  <= s7_back_ff;
         s8_cand_ff  <= s7_cand_ff;
         for (int i = 0; i < 3; i++) begin
            s8_sq_ff[i] <= SQ_W'(s7_dmag_ff[i]) * SQ_W'(s7_dmag_ff[i]);
         end
         s8_rr_ff    <= SQ_W'(radius_ff) * SQ_W'(radius_ff);
         out_hit_ff  <= out_hit_in;
         out_back_ff <= out_hit_in && s8_back_ff;
         out_pt_ff   <= out_pt_in;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_hit       = out_hit_ff;
   assign rsp_hit_x     = out_pt_ff[0];
   assign rsp_hit_y     = out_pt_ff[1];
   assign rsp_hit_z     = out_pt_ff[2];
   assign rsp_back_side = out_back_ff;

   // A miss reports a zero point and no back side
   `RDI_ASSERT(a_miss_zero, rsp_valid && !rsp_hit, rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0 && !rsp_back_side, "miss with nonzero payload")
   // The final remainder stays below the divisor for rays still in play
   `RDI_ASSERT(a_rem_range, div_v_ff[QUO_W] && !div_miss_ff[QUO_W], div_rem_ff[QUO_W] < div_an_ff[QUO_W], "divider remainder out of range")
   // A stall holds the divider output in place
   `RDI_ASSERT_NEXT(a_stall_hold, !pipe_adv, $stable(div_v_ff[QUO_W]) && $stable(div_quo_ff[QUO_W]), "pipeline moved during stall")

endmodule
